// ===== sv/slpc_pkg.sv =====
// Shared types and constants for the status LED pattern controller.
package slpc_pkg;

    // Command codes of an input beat.
    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_BATTERY = 2'd1;
    localparam logic [1:0] CMD_LINK    = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_CRITICAL = 1'b0;
    localparam logic CFG_LOW      = 1'b1;

    // Reset values of the thresholds and of the stored charge.
    localparam logic [6:0] CRITICAL_RESET = 7'd5;
    localparam logic [6:0] LOW_RESET      = 7'd20;
    localparam logic [6:0] CHARGE_RESET   = 7'd100;

    // Countdown lengths in milliseconds.
    localparam logic [9:0] FLASH_MS    = 10'd650;
    localparam logic [9:0] CRIT_ON_MS  = 10'd250;
    localparam logic [9:0] CRIT_OFF_MS = 10'd500;
    localparam logic [9:0] PAIR_MS     = 10'd500;

    // Brightness levels.
    localparam logic [7:0] LEVEL_CRIT  = 8'd64;
    localparam logic [7:0] LEVEL_FLASH = 8'd48;
    localparam logic [7:0] LEVEL_AMBER = 8'd24;
    localparam logic [7:0] LEVEL_PAIR  = 8'd48;
    localparam logic [7:0] LEVEL_LOW   = 8'd24;

    // One input beat.
    typedef struct packed {
        logic [1:0] command;
        logic [6:0] charge_level;
        logic       now_linked;
        logic       now_open;
    } item_t;

    // One rendered colour, with a flag that says whether a colour is produced.
    typedef struct packed {
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    // Timer status seen by the top level.
    typedef struct packed {
        logic armed;
        logic count_zero;
    } timer_status_t;

endpackage

// ===== sv/slpc_core.sv =====
// Controller state and render rule: updates state for one beat and picks the colour.
module slpc_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  slpc_pkg::item_t        item,
    input  logic [6:0]             critical_threshold,
    input  logic [6:0]             low_threshold,
    output slpc_pkg::color_t       result,
    output slpc_pkg::timer_status_t status
);
    import slpc_pkg::*;

    logic [6:0] charge_reg, charge_next;
    logic       linked_reg, linked_next;
    logic       pair_open_reg, pair_open_next;
    logic       link_known_reg, link_known_next;
    logic       blink_phase_reg, blink_phase_next;
    logic       flash_pending_reg, flash_pending_next;
    logic       flash_is_connect_reg, flash_is_connect_next;
    logic [9:0] countdown_reg, countdown_next;
    logic       timer_armed_reg, timer_armed_next;

    // Event handling followed by the render rule on the updated state.
    always_comb
    begin
        logic       run;
        logic       critical;
        logic [9:0] count_dec;

        charge_next           = charge_reg;
        linked_next           = linked_reg;
        pair_open_next        = pair_open_reg;
        link_known_next       = link_known_reg;
        blink_phase_next      = blink_phase_reg;
        flash_pending_next    = flash_pending_reg;
        flash_is_connect_next = flash_is_connect_reg;
        countdown_next        = countdown_reg;
        timer_armed_next      = timer_armed_reg;
        result                = '0;
        run                   = 1'b0;
        count_dec             = (countdown_reg != 10'd0) ? countdown_reg - 10'd1 : countdown_reg;

        unique case (item.command)
            CMD_TICK:
            begin
                if (timer_armed_reg)
                begin
                    if (count_dec != 10'd0)
                    begin
                        countdown_next = count_dec;
                    end
                    else
                    begin
                        countdown_next   = 10'd0;
                        timer_armed_next = 1'b0;
                        run              = 1'b1;
                    end
                end
            end
            CMD_BATTERY:
            begin
                charge_next = item.charge_level;
                run         = 1'b1;
            end
            CMD_LINK:
            begin
                // The first update after reset is only recorded.
                if (link_known_reg && (linked_reg != item.now_linked))
                begin
                    flash_pending_next    = 1'b1;
                    flash_is_connect_next = item.now_linked;
                end
                linked_next     = item.now_linked;
                pair_open_next  = item.now_open;
                link_known_next = 1'b1;
                run             = 1'b1;
            end
            default:
            begin
            end
        endcase

        critical = (charge_next <= critical_threshold);

        // Render rule, checked in priority order.
        if (run)
        begin
            result.valid = 1'b1;
            priority if (flash_pending_next && !critical && !pair_open_next)
            begin
                flash_pending_next = 1'b0;
                if (flash_is_connect_next)
                begin
                    result.green = LEVEL_FLASH;
                end
                else
                begin
                    result.red   = LEVEL_FLASH;
                    result.green = LEVEL_AMBER;
                end
                countdown_next   = FLASH_MS;
                timer_armed_next = 1'b1;
            end
            else if (critical)
            begin
                blink_phase_next = !blink_phase_reg;
                result.red       = blink_phase_next ? LEVEL_CRIT : 8'd0;
                countdown_next   = blink_phase_next ? CRIT_ON_MS : CRIT_OFF_MS;
                timer_armed_next = 1'b1;
            end
            else if (pair_open_next)
            begin
                blink_phase_next = !blink_phase_reg;
                result.blue      = blink_phase_next ? LEVEL_PAIR : 8'd0;
                countdown_next   = PAIR_MS;
                timer_armed_next = 1'b1;
            end
            else
            begin
                blink_phase_next = 1'b0;
                countdown_next   = 10'd0;
                timer_armed_next = 1'b0;
                if (charge_next <= low_threshold)
                begin
                    result.red = LEVEL_LOW;
                end
            end
        end
    end

    // State registers, committed when a beat is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_reg           <= CHARGE_RESET;
            linked_reg           <= 1'b0;
            pair_open_reg        <= 1'b0;
            link_known_reg       <= 1'b0;
            blink_phase_reg      <= 1'b0;
            flash_pending_reg    <= 1'b0;
            flash_is_connect_reg <= 1'b0;
            countdown_reg        <= 10'd0;
            timer_armed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            charge_reg           <= charge_next;
            linked_reg           <= linked_next;
            pair_open_reg        <= pair_open_next;
            link_known_reg       <= link_known_next;
            blink_phase_reg      <= blink_phase_next;
            flash_pending_reg    <= flash_pending_next;
            flash_is_connect_reg <= flash_is_connect_next;
            countdown_reg        <= countdown_next;
            timer_armed_reg      <= timer_armed_next;
        end
    end

    assign status.armed      = timer_armed_reg;
    assign status.count_zero = (countdown_reg == 10'd0);

endmodule

// ===== sv/status_led_pattern_controller_top.sv =====
// Top level of the status LED pattern controller: beat registers, configuration and checks.
//
// Usage: each input beat carries a command (millisecond tick, battery update or
// connection update) with its data. Battery and connection beats always yield one
// colour beat (red, green, blue) on the output channel; a tick yields one only when
// the armed countdown expires, and the unused command yields none.
// A colour beat passes the input register, which holds the accepted beat, and the
// output register, which the render logic writes when the output slot is free. The
// block takes one beat per cycle while the receiver does not stall, set by the single
// render pass between those two registers.
// When the receiver stalls, the output register holds its beat and the input register
// holds the next one; input ready drops only while both are full and the output is
// not taken. Configuration writes (critical and low thresholds) are always ready and
// are meant to be issued while the block is idle.
// Reset clears both beat registers, sets the thresholds to 5 and 20 percent, the stored
// charge to 100 percent, the link state to unknown and disarms the countdown.
module status_led_pattern_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [6:0] charge_level,
    input  logic       now_linked,
    input  logic       now_open,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);
    import slpc_pkg::*;

    logic          in_valid_reg, in_valid_next;
    item_t         in_item_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    red_reg, green_reg, blue_reg;
    logic [6:0]    critical_reg, low_reg;
    logic          advance;
    color_t        result;
    timer_status_t status;

    // Handshake control: the held beat is processed when the output slot is free.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            critical_reg  <= CRITICAL_RESET;
            low_reg       <= LOW_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_CRITICAL: critical_reg <= cfg_data;
                    CFG_LOW:      low_reg      <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers for the input and output beats.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.command      <= command;
            in_item_reg.charge_level <= charge_level;
            in_item_reg.now_linked   <= now_linked;
            in_item_reg.now_open     <= now_open;
        end
        if (advance && result.valid)
        begin
            red_reg   <= result.red;
            green_reg <= result.green;
            blue_reg  <= result.blue;
        end
    end

    slpc_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (advance),
        .item               (in_item_reg),
        .critical_threshold (critical_reg),
        .low_threshold      (low_reg),
        .result             (result),
        .status             (status)
    );

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // The countdown is nonzero exactly when the timer is armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.armed == !status.count_zero)
        else $error("countdown and armed flag disagree");

    // A held beat may not be replaced while the output is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while both beat registers are blocked");

    // A new output beat only appears after a beat was processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(advance))
        else $error("output beat without a processed input beat");

    // A held output beat with no processing stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("stalled output beat dropped");

endmodule

// ===== bench/status_led_pattern_controller_top_tb.sv =====
// Self-checking testbench for the status LED pattern controller top level.
module status_led_pattern_controller_top_tb;

    import slpc_pkg::*;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Run bounds: timeout in clock cycles, random steps, and settle cycles after the
    // last expected colour.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_STEPS = 160;
    localparam int unsigned NUM_PHASES   = 8;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned PRINT_CAP    = 100;

    // Predicts the colour beats of the block and checks the ones it produces.
    class led_color_tracker;
        logic [6:0] crit_thr;
        logic [6:0] low_thr;
        logic [6:0] charge;
        logic [9:0] countdown;
        bit         linked;
        bit         pair_open;
        bit         link_known;
        bit         blink_phase;
        bit         flash_pending;
        bit         flash_is_connect;
        bit         timer_armed;
        color_t     due_colors[$];
        int unsigned errors;

        function new();
            crit_thr         = CRITICAL_RESET;
            low_thr          = LOW_RESET;
            charge           = CHARGE_RESET;
            countdown        = '0;
            linked           = 0;
            pair_open        = 0;
            link_known       = 0;
            blink_phase      = 0;
            flash_pending    = 0;
            flash_is_connect = 0;
            timer_armed      = 0;
            errors           = 0;
        endfunction

        function void set_threshold(logic idx, logic [6:0] val);
            if (idx == CFG_CRITICAL)
                crit_thr = val;
            else
                low_thr = val;
        endfunction

        function int unsigned pending();
            return due_colors.size();
        endfunction

        // Applies the priority rule: flash, critical blink, pairing blink, low, off.
        function color_t render_color();
            color_t c;
            bit     critical;
            c        = '0;
            c.valid  = 1'b1;
            critical = (charge <= crit_thr);
            if (flash_pending && !critical && !pair_open) begin
                flash_pending = 0;
                if (flash_is_connect) begin
                    c.green = LEVEL_FLASH;
                end
                else begin
                    c.red   = LEVEL_FLASH;
                    c.green = LEVEL_AMBER;
                end
                countdown   = FLASH_MS;
                timer_armed = 1;
            end
            else if (critical) begin
                blink_phase = !blink_phase;
                c.red       = blink_phase ? LEVEL_CRIT : 8'd0;
                countdown   = blink_phase ? CRIT_ON_MS : CRIT_OFF_MS;
                timer_armed = 1;
            end
            else if (pair_open) begin
                blink_phase = !blink_phase;
                c.blue      = blink_phase ? LEVEL_PAIR : 8'd0;
                countdown   = PAIR_MS;
                timer_armed = 1;
            end
            else begin
                blink_phase = 0;
                timer_armed = 0;
                countdown   = '0;
                if (charge <= low_thr)
                    c.red = LEVEL_LOW;
            end
            return c;
        endfunction

        // Updates the state for one accepted input beat and queues its colour, if any.
        function void absorb_beat(item_t it);
            case (it.command)
                CMD_TICK: begin
                    if (timer_armed) begin
                        if (countdown > 0)
                            countdown = countdown - 10'd1;
                        if (countdown == 0) begin
                            timer_armed = 0;
                            due_colors.push_back(render_color());
                        end
                    end
                end
                CMD_BATTERY: begin
                    charge = it.charge_level;
                    due_colors.push_back(render_color());
                end
                CMD_LINK: begin
                    // The first update after reset only records the link state.
                    if (link_known && (linked != it.now_linked)) begin
                        flash_pending    = 1;
                        flash_is_connect = it.now_linked;
                    end
                    linked     = it.now_linked;
                    pair_open  = it.now_open;
                    link_known = 1;
                    due_colors.push_back(render_color());
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one produced colour beat with the oldest expectation.
        task check_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            color_t exp_c;
            if (due_colors.size() == 0) begin
                report_mismatch($sformatf("unexpected colour (%0d,%0d,%0d)", r, g, b));
                return;
            end
            exp_c = due_colors.pop_front();
            if (r !== exp_c.red)
                report_mismatch($sformatf("red %0d, expected %0d", r, exp_c.red));
            if (g !== exp_c.green)
                report_mismatch($sformatf("green %0d, expected %0d", g, exp_c.green));
            if (b !== exp_c.blue)
                report_mismatch($sformatf("blue %0d, expected %0d", b, exp_c.blue));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [6:0] charge_level;
    logic       now_linked;
    logic       now_open;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [6:0] cfg_data;

    led_color_tracker tracker;
    bit               no_gaps;
    int unsigned      cycle_count;

    status_led_pattern_controller_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .charge_level (charge_level),
        .now_linked   (now_linked),
        .now_open     (now_open),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Timeout watchdog.
    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output beat checking at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_color(red, green, blue);
    end

    // Receiver back-pressure: stretches of steady ready, random stalls and long stalls.
    initial
    begin : recv_pressure
        int unsigned mode;
        int unsigned len;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            mode = $urandom_range(0, 9);
            len  = (mode >= 8) ? $urandom_range(10, 60) : $urandom_range(10, 200);
            repeat (len) begin
                @(negedge clk);
                if (mode < 4)
                    out_ready <= 1'b1;
                else if (mode < 8)
                    out_ready <= ($urandom_range(0, 99) >= 30);
                else
                    out_ready <= ($urandom_range(0, 99) < 5);
            end
        end
    end

    // Idle length before an input beat: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Charge values biased toward the thresholds and the field extremes.
    function automatic logic [6:0] pick_charge();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 25)
            v = $urandom_range(0, 127);
        else if (r < 50)
            v = int'(tracker.crit_thr) + $urandom_range(0, 4) - 2;
        else if (r < 75)
            v = int'(tracker.low_thr) + $urandom_range(0, 4) - 2;
        else if (r < 85)
            v = ($urandom_range(0, 1) == 1) ? 127 : 0;
        else
            v = $urandom_range(0, 100);
        if (v < 0)
            v = 0;
        if (v > 127)
            v = 127;
        return 7'(v);
    endfunction

    // Sends one input beat and records it once it is accepted.
    task automatic send_item(logic [1:0] cmd, logic [6:0] lvl, logic lk, logic op);
        item_t       it;
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        it.command      = cmd;
        it.charge_level = lvl;
        it.now_linked   = lk;
        it.now_open     = op;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        charge_level <= lvl;
        now_linked   <= lk;
        now_open     <= op;
        do @(posedge clk); while (!in_ready);
        tracker.absorb_beat(it);
    endtask

    // Tick beats with random unused payload bits.
    task automatic run_ticks(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            send_item(CMD_TICK, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
    endtask

    // Ticks until the pending countdown expires, then sometimes a few idle ticks.
    task automatic run_to_expiry();
        int unsigned n;
        n = tracker.timer_armed ? int'(tracker.countdown) : $urandom_range(1, 5);
        if ($urandom_range(0, 4) == 0)
            n += $urandom_range(1, 3);
        run_ticks(n);
    endtask

    // Lowers input valid and waits until every expected colour beat has come out.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes one threshold register; the block must be idle.
    task automatic write_cfg(logic idx, logic [6:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_threshold(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Directed sequence under the reset thresholds (critical 5, low 20).
    task automatic run_directed();
        // A tick with no countdown armed and the unused command produce nothing.
        send_item(CMD_TICK, 7'd0, 1'b0, 1'b0);
        send_item(CMD_UNUSED, 7'd127, 1'b1, 1'b1);
        // The first link update is only recorded; a later change flashes amber.
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b0);
        send_item(CMD_LINK, 7'd0, 1'b0, 1'b0);
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b0);
        // Pairing blink, then two link changes held back; the later one wins.
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b1);
        send_item(CMD_LINK, 7'd0, 1'b0, 1'b1);
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b1);
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b0);
        // A flash held back by a critical battery shows once the charge recovers.
        send_item(CMD_BATTERY, 7'd5, 1'b0, 1'b0);
        send_item(CMD_LINK, 7'd0, 1'b0, 1'b0);
        send_item(CMD_BATTERY, 7'd127, 1'b1, 1'b1);
        send_item(CMD_BATTERY, 7'd20, 1'b0, 1'b0);
        send_item(CMD_BATTERY, 7'd0, 1'b0, 1'b0);
        send_item(CMD_BATTERY, 7'd100, 1'b0, 1'b0);
        // Countdown expiry of a critical blink; pairing and flash countdowns keep running.
        send_item(CMD_BATTERY, 7'd3, 1'b0, 1'b0);
        run_to_expiry();
        send_item(CMD_BATTERY, 7'd21, 1'b0, 1'b0);
        send_item(CMD_BATTERY, 7'd6, 1'b0, 1'b0);
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b1);
        run_ticks(4);
        send_item(CMD_LINK, 7'd0, 1'b1, 1'b0);
        run_ticks(4);
        run_ticks(2);
    endtask

    // One random step: an event beat, noise or a short tick run.
    task automatic random_step();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            send_item(CMD_BATTERY, pick_charge(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        else if (sel < 65)
            send_item(CMD_LINK, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 99) < 30));
        else if (sel < 68)
            send_item(CMD_UNUSED, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        else
            run_ticks($urandom_range(1, 20));
    endtask

    // Main stimulus.
    initial
    begin : stimulus
        logic [6:0] crit_set;
        logic [6:0] low_set;
        tracker      = new();
        no_gaps      = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_TICK;
        charge_level = '0;
        now_linked   = 1'b0;
        now_open     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_CRITICAL;
        cfg_data     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // Threshold settings per phase: extremes, a crossed pair, defaults, then random.
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin crit_set = 7'd0;   low_set = 7'd0;   end
                1: begin crit_set = 7'd100; low_set = 7'd100; end
                2: begin crit_set = 7'd0;   low_set = 7'd100; end
                3: begin crit_set = 7'd60;  low_set = 7'd30;  end
                4: begin crit_set = CRITICAL_RESET; low_set = LOW_RESET; end
                default: begin
                    crit_set = 7'($urandom_range(0, 100));
                    low_set  = 7'($urandom_range(0, 100));
                end
            endcase
            drain();
            write_cfg(CFG_CRITICAL, crit_set);
            write_cfg(CFG_LOW, low_set);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int unsigned step = 0; step < RANDOM_STEPS / NUM_PHASES; step++)
                random_step();
        end

        drain();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/slpc_pkg.sv
sv/slpc_core.sv
sv/status_led_pattern_controller_top.sv
bench/status_led_pattern_controller_top_tb.sv
